FILE: sv/srmq_pkg.sv
package srmq_pkg;

  localparam int MAX_LEN = 1024;
  localparam int LEVELS  = 11;

  localparam int IDX_W  = $clog2(MAX_LEN);
  localparam int CNT_W  = IDX_W + 1;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int DEPTH  = LEVELS * MAX_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int VAL_W  = 32;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BOUNDS    = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_LOAD  = 2'd0,
    K_QUERY = 2'd1,
    K_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              wr;      // load stores its value
    logic              build;   // load closes the array
    logic [VAL_W-1:0]  value;
    logic [IDX_W-1:0]  col_a;   // load slot, or left block of a query
    logic [IDX_W-1:0]  col_b;   // right block of a query
    logic [LVL_W-1:0]  level;
    logic [CNT_W-1:0]  count;   // element count after the load
    status_t           status;
  } entry_t;

  function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (x[i]) r = LVL_W'(i);
    end
    if (r > LVL_W'(LEVELS - 1)) r = LVL_W'(LEVELS - 1);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [IDX_W-1:0] col);
    return ADDR_W'(lvl) * ADDR_W'(MAX_LEN) + ADDR_W'(col);
  endfunction

endpackage

FILE: sv/sparse_table_range_max_core.sv
// Sparse-table range maximum. Loads append signed values (up to 1024); the
// load marked last builds a table of power-of-two block maxima in one table
// memory with one write and two read ports. The input side takes one
// transaction per cycle while its 4-entry queue has room. In the back end a
// load writes level 0 directly, a query reads the table and then compares
// into the output register, and a rejected query goes to the output register
// directly. The build after the last load reads one block pair per cycle
// within a level on the two read ports, level by level, and holds later
// transactions in the queue. The table needs no clearing after reset.
module sparse_table_range_max_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic signed [31:0]  in_value,
  input  logic                in_last_load,
  input  logic [9:0]          in_left,
  input  logic [9:0]          in_right,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_max_value,
  output logic [9:0]          out_max_index,
  output logic [1:0]          out_status
);
  import srmq_pkg::*;

  logic   q_full, q_push, q_pop, q_valid;
  entry_t push_entry, head_entry;

  srmq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_value     (in_value),
    .in_last_load (in_last_load),
    .in_left      (in_left),
    .in_right     (in_right),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  srmq_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  srmq_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_entry       (head_entry),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_max_value (out_max_value),
    .out_max_index (out_max_index),
    .out_status    (out_status)
  );

endmodule

FILE: sv/srmq_front.sv
module srmq_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic signed [31:0]    in_value,
  input  logic                  in_last_load,
  input  logic [9:0]            in_left,
  input  logic [9:0]            in_right,
  input  logic                  q_full,
  output logic                  q_push,
  output srmq_pkg::entry_t      q_entry
);
  import srmq_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ready_r, ready_nxt;
  logic [CNT_W-1:0] cnt_eff;
  logic             store;
  logic [CNT_W-1:0] len;
  logic [LVL_W-1:0] lvl;
  logic [CNT_W-1:0] col_b_wide;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    // a load after a build starts a new array
    cnt_eff    = ready_r ? '0 : count_r;
    store      = cnt_eff < CNT_W'(MAX_LEN);
    len        = {1'b0, in_right} - {1'b0, in_left} + CNT_W'(1);
    lvl        = floor_log2(len);
    col_b_wide = {1'b0, in_right} + CNT_W'(1) - (CNT_W'(1) << lvl);

    count_nxt = count_r;
    ready_nxt = ready_r;

    q_entry        = '0;
    q_entry.value  = in_value;
    q_entry.level  = lvl;
    q_entry.status = ST_OK;

    if (in_op == OP_LOAD) begin
      q_entry.kind  = K_LOAD;
      q_entry.wr    = store;
      q_entry.build = in_last_load;
      q_entry.col_a = cnt_eff[IDX_W-1:0];
      q_entry.count = cnt_eff + CNT_W'(store);
      count_nxt     = cnt_eff + CNT_W'(store);
      ready_nxt     = in_last_load;
    end else if (!ready_r) begin
      q_entry.kind   = K_ERROR;
      q_entry.status = ST_NOT_BUILT;
    end else if (in_left > in_right || {1'b0, in_right} >= count_r) begin
      q_entry.kind   = K_ERROR;
      q_entry.status = ST_BOUNDS;
    end else begin
      q_entry.kind  = K_QUERY;
      q_entry.col_a = in_left;
      q_entry.col_b = col_b_wide[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ready_r <= 1'b0;
    end else if (q_push) begin
      count_r <= count_nxt;
      ready_r <= ready_nxt;
    end
  end

endmodule

FILE: sv/srmq_fifo.sv
module srmq_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  srmq_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output srmq_pkg::entry_t  head_entry
);
  import srmq_pkg::*;

  entry_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;
  logic                do_pop;

  assign full       = cnt_r == (QPTR_W+1)'(QDEPTH);
  assign head_valid = cnt_r != '0;
  assign head_entry = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: sv/srmq_back.sv
module srmq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  srmq_pkg::entry_t      q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_max_value,
  output logic [9:0]            out_max_index,
  output logic [1:0]            out_status
);
  import srmq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_BLD_RD, S_BLD_DRAIN, S_Q_CMP} state_t;

  logic [VAL_W-1:0] mem_val [DEPTH];
  logic [IDX_W-1:0] mem_arg [DEPTH];

  state_t           state_r, state_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             wpend_r, wpend_nxt;
  logic [LVL_W-1:0] wlvl_r, wlvl_nxt;
  logic [IDX_W-1:0] wcol_r, wcol_nxt;

  logic [VAL_W-1:0] rd_val_a_r, rd_val_b_r;
  logic [IDX_W-1:0] rd_arg_a_r, rd_arg_b_r;

  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_val_r, out_val_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  status_t          out_st_r, out_st_nxt;

  logic              rd_en, we;
  logic [ADDR_W-1:0] ra, rb, waddr;
  logic [VAL_W-1:0]  wval;
  logic [IDX_W-1:0]  warg;
  logic              a_wins;
  logic [VAL_W-1:0]  pick_val;
  logic [IDX_W-1:0]  pick_arg;
  logic [CNT_W:0]    span;
  logic [IDX_W-1:0]  half;
  logic              out_free;

  assign out_valid     = out_valid_r;
  assign out_max_value = $signed(out_val_r);
  assign out_max_index = out_idx_r;
  assign out_status    = out_st_r;

  always_comb begin
    // right block wins a tie
    a_wins   = $signed(rd_val_a_r) > $signed(rd_val_b_r);
    pick_val = a_wins ? rd_val_a_r : rd_val_b_r;
    pick_arg = a_wins ? rd_arg_a_r : rd_arg_b_r;
    span     = (CNT_W+1)'(1) << lvl_r;
    half     = IDX_W'(span >> 1);
    out_free = !out_valid_r || !out_stall;

    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    col_nxt   = col_r;
    n_nxt     = n_r;
    wpend_nxt = wpend_r;
    wlvl_nxt  = wlvl_r;
    wcol_nxt  = wcol_r;

    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    q_pop = 1'b0;
    rd_en = 1'b0;
    ra    = '0;
    rb    = '0;

    // build write lands in the cycle after its reads
    we    = wpend_r;
    waddr = mem_addr(wlvl_r, wcol_r);
    wval  = pick_val;
    warg  = pick_arg;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          case (q_entry.kind)
            K_LOAD: begin
              q_pop = 1'b1;
              if (q_entry.wr) begin
                we    = 1'b1;
                waddr = mem_addr('0, q_entry.col_a);
                wval  = q_entry.value;
                warg  = q_entry.col_a;
              end
              if (q_entry.build && q_entry.count >= CNT_W'(2)) begin
                n_nxt     = q_entry.count;
                lvl_nxt   = LVL_W'(1);
                col_nxt   = '0;
                state_nxt = S_BLD_RD;
              end
            end
            K_QUERY: begin
              q_pop     = 1'b1;
              rd_en     = 1'b1;
              ra        = mem_addr(q_entry.level, q_entry.col_a);
              rb        = mem_addr(q_entry.level, q_entry.col_b);
              state_nxt = S_Q_CMP;
            end
            K_ERROR: begin
              if (out_free) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                out_val_nxt   = '0;
                out_idx_nxt   = '0;
                out_st_nxt    = q_entry.status;
              end
            end
            default: ;
          endcase
        end
      end
      S_BLD_RD: begin
        rd_en     = 1'b1;
        ra        = mem_addr(lvl_r - 1'b1, col_r);
        rb        = mem_addr(lvl_r - 1'b1, col_r + half);
        wpend_nxt = 1'b1;
        wlvl_nxt  = lvl_r;
        wcol_nxt  = col_r;
        if ((CNT_W+1)'(col_r) + (CNT_W+1)'(1) + span <= (CNT_W+1)'(n_r)) begin
          col_nxt = col_r + 1'b1;
        end else begin
          state_nxt = S_BLD_DRAIN;
        end
      end
      S_BLD_DRAIN: begin
        // let the last write of this level land before the next level reads it
        wpend_nxt = 1'b0;
        if ((LVL_W+1)'(lvl_r) + 1'b1 < (LVL_W+1)'(LEVELS) &&
            (span << 1) <= (CNT_W+1)'(n_r)) begin
          lvl_nxt   = lvl_r + 1'b1;
          col_nxt   = '0;
          state_nxt = S_BLD_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_Q_CMP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = pick_val;
          out_idx_nxt   = pick_arg;
          out_st_nxt    = ST_OK;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_val[waddr] <= wval;
      mem_arg[waddr] <= warg;
    end
    if (rd_en) begin
      rd_val_a_r <= mem_val[ra];
      rd_val_b_r <= mem_val[rb];
      rd_arg_a_r <= mem_arg[ra];
      rd_arg_b_r <= mem_arg[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lvl_r     <= lvl_nxt;
    col_r     <= col_nxt;
    n_r       <= n_nxt;
    wlvl_r    <= wlvl_nxt;
    wcol_r    <= wcol_nxt;
    out_val_r <= out_val_nxt;
    out_idx_r <= out_idx_nxt;
    out_st_r  <= out_st_nxt;
  end

endmodule

FILE: sv/srmq_checker.sv
module srmq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_max_value,
  input logic [9:0]         out_max_index,
  input logic [1:0]         out_status
);
  import srmq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_max_value) && $stable(out_max_index) &&
                               $stable(out_status))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_BOUNDS ||
                  out_status == ST_NOT_BUILT)
    else $error("undefined status code");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_max_value == 0 && out_max_index == 0)
    else $error("rejected query carries data");

endmodule

bind sparse_table_range_max_core srmq_checker u_srmq_checker (.*);

FILE: tb/tb_sparse_table_range_max_core.sv
module tb_sparse_table_range_max_core;
  timeunit 1ns;
  timeprecision 1ps;

  import srmq_pkg::*;

  localparam int TARGET_TXNS = 1950;
  localparam int FULL_LOADS  = MAX_LEN + 2;

  typedef struct {
    logic signed [VAL_W-1:0] max_value;
    logic [IDX_W-1:0]        max_index;
    status_t                 status;
  } range_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_op = OP_LOAD;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    in_last_load = 1'b0;
  logic [IDX_W-1:0]        in_left = '0;
  logic [IDX_W-1:0]        in_right = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_max_value;
  logic [IDX_W-1:0]        out_max_index;
  logic [1:0]              out_status;

  // predictor state: block maxima per level and the index of each maximum
  logic signed [VAL_W-1:0] blk_max [LEVELS][MAX_LEN];
  logic [IDX_W-1:0]        blk_arg [LEVELS][MAX_LEN];
  int                      elem_count = 0;
  bit                      table_built = 1'b0;

  range_result_t pending_maxima[$];
  range_result_t want;
  int            error_count = 0;
  int            txn_count = 0;
  int            burst_left = 0;
  int            stall_mode = 0;
  int            stall_run = 0;

  sparse_table_range_max_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_value     (in_value),
    .in_last_load (in_last_load),
    .in_left      (in_left),
    .in_right     (in_right),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_max_value(out_max_value),
    .out_max_index(out_max_index),
    .out_status   (out_status)
  );

  always #2 clk = ~clk;

  task automatic predict_range_max(input logic op, input logic signed [VAL_W-1:0] val,
                                   input logic last, input logic [IDX_W-1:0] lo,
                                   input logic [IDX_W-1:0] hi);
    range_result_t res;
    int half;
    int span;
    int lvl;
    int col_b;
    if (op == OP_LOAD) begin
      // a load after a build starts a new array
      if (table_built) begin
        table_built = 1'b0;
        elem_count = 0;
      end
      if (elem_count < MAX_LEN) begin
        blk_max[0][elem_count] = val;
        blk_arg[0][elem_count] = IDX_W'(elem_count);
        elem_count++;
      end
      if (last) begin
        for (int p = 1; p < LEVELS && (1 << p) <= elem_count; p++) begin
          half = 1 << (p - 1);
          for (int i = 0; i + (1 << p) <= elem_count; i++) begin
            // right half wins a tie
            if (blk_max[p-1][i] > blk_max[p-1][i+half]) begin
              blk_max[p][i] = blk_max[p-1][i];
              blk_arg[p][i] = blk_arg[p-1][i];
            end else begin
              blk_max[p][i] = blk_max[p-1][i+half];
              blk_arg[p][i] = blk_arg[p-1][i+half];
            end
          end
        end
        table_built = 1'b1;
      end
    end else begin
      res.max_value = '0;
      res.max_index = '0;
      if (!table_built) begin
        res.status = ST_NOT_BUILT;
      end else if (lo > hi || int'(hi) >= elem_count) begin
        res.status = ST_BOUNDS;
      end else begin
        span = int'(hi) - int'(lo) + 1;
        lvl = 0;
        while ((2 << lvl) <= span) lvl++;
        if (lvl > LEVELS - 1) lvl = LEVELS - 1;
        col_b = int'(hi) + 1 - (1 << lvl);
        if (blk_max[lvl][lo] > blk_max[lvl][col_b]) begin
          res.max_value = blk_max[lvl][lo];
          res.max_index = blk_arg[lvl][lo];
        end else begin
          res.max_value = blk_max[lvl][col_b];
          res.max_index = blk_arg[lvl][col_b];
        end
        res.status = ST_OK;
      end
      pending_maxima.push_back(res);
    end
  endtask

  task automatic idle_cycles(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      idle_cycles($urandom_range(1, 8));
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_maxima.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(input logic op, input logic signed [VAL_W-1:0] val,
                           input logic last, input logic [IDX_W-1:0] lo,
                           input logic [IDX_W-1:0] hi);
    in_valid     <= 1'b1;
    in_op        <= op;
    in_value     <= val;
    in_last_load <= last;
    in_left      <= lo;
    in_right     <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    txn_count++;
    predict_range_max(op, val, last, lo, hi);
    pace_sender();
  endtask

  task automatic load_elem(input logic signed [VAL_W-1:0] val, input logic last);
    send_item(OP_LOAD, val, last, IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic ask_range(input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
    send_item(OP_QUERY, $urandom, 1'($urandom), lo, hi);
  endtask

  // extremes and small values, so that ties show up often
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed_cases();
    ask_range(0, 0);
    ask_range(1023, 1023);
    load_elem(32'sh8000_0000, 1'b1);
    ask_range(0, 0);
    ask_range(0, 1);
    ask_range(1, 0);
    load_elem(32'sh7fff_ffff, 1'b0);
    load_elem(32'sh8000_0000, 1'b0);
    load_elem(32'sh7fff_ffff, 1'b0);
    load_elem(32'sh0000_0000, 1'b0);
    load_elem(-32'sd1, 1'b1);
    ask_range(0, 4);
    ask_range(0, 1);
    ask_range(1, 1);
    ask_range(3, 4);
    ask_range(1, 4);
    ask_range(2, 3);
    ask_range(4, 4);
    ask_range(5, 5);
    // new array: the old table is gone until the next build
    load_elem(32'sd5, 1'b0);
    ask_range(0, 0);
    load_elem(32'sd5, 1'b1);
    ask_range(0, 1);
    wait_drain();
  endtask

  task automatic test_full_array();
    logic [IDX_W-1:0] lo;
    // the last two loads overflow and are dropped; the final one still builds
    for (int i = 0; i < FULL_LOADS; i++) load_elem(pick_value(), i == FULL_LOADS - 1);
    ask_range(0, 1023);
    ask_range(1023, 1023);
    ask_range(0, 0);
    ask_range(511, 512);
    ask_range(1, 1023);
    ask_range(0, 1022);
    repeat (20) begin
      lo = IDX_W'($urandom_range(0, 1023));
      ask_range(lo, IDX_W'($urandom_range(int'(lo), 1023)));
    end
  endtask

  task automatic test_random_arrays();
    int n;
    int nq;
    int pick;
    int lo;
    int hi;
    while (txn_count < TARGET_TXNS) begin
      n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 40) : $urandom_range(41, 300);
      for (int i = 0; i < n; i++) begin
        // stray query mid-load sees no table
        if (i > 0 && $urandom_range(0, 19) == 0)
          ask_range(IDX_W'($urandom), IDX_W'($urandom));
        load_elem(pick_value(), i == n - 1);
      end
      nq = $urandom_range(1, 40);
      for (int q = 0; q < nq; q++) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          lo = $urandom_range(0, n - 1);
          hi = $urandom_range(lo, n - 1);
        end else if (pick == 7) begin
          lo = $urandom_range(0, 1) ? 0 : $urandom_range(0, n - 1);
          hi = (lo == 0) ? n - 1 : lo;
        end else if (pick == 8) begin
          hi = $urandom_range(0, 1022);
          lo = $urandom_range(hi + 1, 1023);
        end else begin
          hi = $urandom_range(n, 1023);
          lo = $urandom_range(0, 1023);
        end
        ask_range(IDX_W'(lo), IDX_W'(hi));
      end
      if ($urandom_range(0, 9) == 0) wait_drain();
    end
  endtask

  // receiver stall: stretches of no stall, light, heavy and long blocks
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(16, 200);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_run[5];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_maxima.size() == 0) begin
        $display("%0t: unexpected result max_value %0d max_index %0d status %0d",
                 $time, out_max_value, out_max_index, out_status);
        error_count++;
      end else begin
        want = pending_maxima.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_max_value !== want.max_value) begin
          $display("%0t: max_value expected %0d got %0d",
                   $time, want.max_value, out_max_value);
          error_count++;
        end
        if (out_max_index !== want.max_index) begin
          $display("%0t: max_index expected %0d got %0d",
                   $time, want.max_index, out_max_index);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_full_array();
    test_random_arrays();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_maxima.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
sv/srmq_pkg.sv
sv/srmq_front.sv
sv/srmq_fifo.sv
sv/srmq_back.sv
sv/sparse_table_range_max_core.sv
sv/srmq_checker.sv
tb/tb_sparse_table_range_max_core.sv
